// ===== hdl/rofr_pkg.sv =====
// Shared types and constants for the rectangle rasterizer.
// Request and status codes, controller states, command and status bundles.
`default_nettype none

package rofr_pkg;

    localparam int COORD_W = 20;
    localparam int BYTE_W  = 8;
    localparam int CFG_W   = 9;
    localparam int CIDX_W  = 2;
    localparam int POS_W   = 8;

    localparam logic [CIDX_W-1:0] REG_CANVAS_WIDTH  = 2'd0;
    localparam logic [CIDX_W-1:0] REG_CANVAS_HEIGHT = 2'd1;
    localparam logic [CIDX_W-1:0] REG_BACKGROUND    = 2'd2;

    localparam logic [CFG_W-1:0]  WIDTH_RESET  = 9'd256;
    localparam logic [CFG_W-1:0]  HEIGHT_RESET = 9'd256;
    localparam logic [BYTE_W-1:0] BG_RESET     = 8'd32;

    localparam logic [BYTE_W-1:0] KIND_FILLED  = 8'h52;  // 'R'
    localparam logic [BYTE_W-1:0] KIND_OUTLINE = 8'h72;  // 'r'

    typedef enum logic [1:0] {
        REQ_CLEAR = 2'd0,
        REQ_DRAW  = 2'd1,
        REQ_READ  = 2'd2,
        REQ_NONE  = 2'd3
    } req_t;

    typedef enum logic [1:0] {
        STAT_OK      = 2'd0,
        STAT_REJECT  = 2'd1,
        STAT_OUTSIDE = 2'd2
    } stat_code_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECODE,
        ST_SWEEP,
        ST_READ,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic in_ready;
        logic setup;
        logic sweep;
        logic rd_en;
        logic load_result;
    } ctl_cmd_t;

    typedef struct packed {
        req_t req;
        logic reject;
        logic empty;
        logic last_pixel;
        logic slot_free;
    } dp_stat_t;

endpackage

`default_nettype wire

// ===== hdl/rofr_req_if.sv =====
// Request channel: valid/ready handshake carrying one request beat.
// Uses rofr_pkg for field widths.
`default_nettype none

interface rofr_req_if
    import rofr_pkg::*;
();
    logic                      valid;
    logic                      ready;
    logic [1:0]                req_type;
    logic [BYTE_W-1:0]         rect_kind;
    logic signed [COORD_W-1:0] rect_left;
    logic signed [COORD_W-1:0] rect_top;
    logic signed [COORD_W-1:0] rect_span_x;
    logic signed [COORD_W-1:0] rect_span_y;
    logic [BYTE_W-1:0]         rect_color;
    logic [POS_W-1:0]          read_col;
    logic [POS_W-1:0]          read_row;

    modport source (
        output valid, req_type, rect_kind, rect_left, rect_top,
               rect_span_x, rect_span_y, rect_color, read_col, read_row,
        input  ready
    );

    modport sink (
        input  valid, req_type, rect_kind, rect_left, rect_top,
               rect_span_x, rect_span_y, rect_color, read_col, read_row,
        output ready
    );
endinterface

`default_nettype wire

// ===== hdl/rofr_rsp_if.sv =====
// Response channel: valid/ready handshake carrying one result beat.
// Uses rofr_pkg for field widths.
`default_nettype none

interface rofr_rsp_if
    import rofr_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [1:0]        status;
    logic [BYTE_W-1:0] pixel_value;

    modport source (
        output valid, status, pixel_value,
        input  ready
    );

    modport sink (
        input  valid, status, pixel_value,
        output ready
    );
endinterface

`default_nettype wire

// ===== hdl/rofr_ctrl.sv =====
// Request sequencer: accepts a beat, walks decode, sweep or read, then posts the result.
// Uses rofr_pkg for states and the command/status bundles.
`default_nettype none

module rofr_ctrl
    import rofr_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     in_valid,
    input  wire dp_stat_t stat,
    output ctl_cmd_t      cmd
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_DECODE;
                end
            end
            ST_DECODE:
            begin
                unique case (stat.req)
                    REQ_CLEAR: state_next = stat.empty ? ST_FINISH : ST_SWEEP;
                    REQ_DRAW:  state_next = (stat.reject || stat.empty) ? ST_FINISH : ST_SWEEP;
                    REQ_READ:  state_next = ST_READ;
                    REQ_NONE:  state_next = ST_FINISH;
                endcase
            end
            ST_SWEEP:
            begin
                if (stat.last_pixel)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_READ:
            begin
                state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                if (stat.slot_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd             = '0;
        cmd.in_ready    = (state_reg == ST_IDLE);
        cmd.setup       = (state_reg == ST_DECODE);
        cmd.sweep       = (state_reg == ST_SWEEP);
        cmd.rd_en       = (state_reg == ST_READ);
        cmd.load_result = (state_reg == ST_FINISH) && stat.slot_free;
    end

endmodule

`default_nettype wire

// ===== hdl/rofr_datapath.sv =====
// Canvas memory, request capture, edge thresholds, sweep counters and result register.
// Uses rofr_pkg, rofr_req_if and rofr_rsp_if.
`default_nettype none

module rofr_datapath
    import rofr_pkg::*;
#(
    parameter int MAX_COLS  = 256,
    parameter int MAX_ROWS  = 256,
    parameter int FRAC_BITS = 8
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              cfg_we,
    input  wire logic [CIDX_W-1:0] cfg_index,
    input  wire logic [CFG_W-1:0]  cfg_data,
    rofr_req_if.sink               req,
    rofr_rsp_if.source             rsp,
    input  wire ctl_cmd_t          cmd,
    output dp_stat_t               stat
);

    localparam int DEPTH = MAX_COLS * MAX_ROWS;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int WW    = $clog2(MAX_COLS + 1);
    localparam int HW    = $clog2(MAX_ROWS + 1);
    localparam int GW    = (WW > HW) ? WW : HW;
    localparam int VW0   = GW + FRAC_BITS + 1;
    localparam int VW    = (VW0 > COORD_W + 2) ? VW0 : COORD_W + 2;
    localparam int PW    = POS_W + WW;
    localparam int SW    = ((AW > PW) ? AW : PW) + 1;
    localparam logic signed [VW-1:0] ONE_FX = VW'(1 << FRAC_BITS);

    // configuration
    logic [CFG_W-1:0]  cw_reg;
    logic [CFG_W-1:0]  ch_reg;
    logic [BYTE_W-1:0] bg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cw_reg <= WIDTH_RESET;
            ch_reg <= HEIGHT_RESET;
            bg_reg <= BG_RESET;
        end
        else if (cfg_we)
        begin
            if (cfg_index == REG_CANVAS_WIDTH)
            begin
                cw_reg <= cfg_data;
            end
            if (cfg_index == REG_CANVAS_HEIGHT)
            begin
                ch_reg <= cfg_data;
            end
            if (cfg_index == REG_BACKGROUND)
            begin
                bg_reg <= cfg_data[BYTE_W-1:0];
            end
        end
    end

    logic [WW-1:0] w_eff;
    logic [HW-1:0] h_eff;

    assign w_eff = (int'(cw_reg) > MAX_COLS) ? WW'(MAX_COLS) : WW'(cw_reg);
    assign h_eff = (int'(ch_reg) > MAX_ROWS) ? HW'(MAX_ROWS) : HW'(ch_reg);

    // captured request
    logic                      capture;
    req_t                      req_reg;
    logic [BYTE_W-1:0]         kind_reg;
    logic signed [COORD_W-1:0] left_reg;
    logic signed [COORD_W-1:0] top_reg;
    logic signed [COORD_W-1:0] spx_reg;
    logic signed [COORD_W-1:0] spy_reg;
    logic [BYTE_W-1:0]         color_reg;
    logic [POS_W-1:0]          rcol_reg;
    logic [POS_W-1:0]          rrow_reg;

    assign capture   = cmd.in_ready && req.valid;
    assign req.ready = cmd.in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_reg <= REQ_NONE;
        end
        else if (capture)
        begin
            req_reg <= req_t'(req.req_type);
        end
    end

    always_ff @(posedge clk)
    begin
        if (capture)
        begin
            kind_reg  <= req.rect_kind;
            left_reg  <= req.rect_left;
            top_reg   <= req.rect_top;
            spx_reg   <= req.rect_span_x;
            spy_reg   <= req.rect_span_y;
            color_reg <= req.rect_color;
            rcol_reg  <= req.read_col;
            rrow_reg  <= req.read_row;
        end
    end

    logic reject;

    assign reject = spx_reg[COORD_W-1] || (spx_reg == '0)
                 || spy_reg[COORD_W-1] || (spy_reg == '0)
                 || ((kind_reg != KIND_FILLED) && (kind_reg != KIND_OUTLINE));

    // edge thresholds
    logic signed [VW-1:0] l_ext;
    logic signed [VW-1:0] t_ext;
    logic signed [VW-1:0] sx_ext;
    logic signed [VW-1:0] sy_ext;
    logic signed [VW-1:0] x_lo_reg;
    logic signed [VW-1:0] x_hi_reg;
    logic signed [VW-1:0] x_in_lo_reg;
    logic signed [VW-1:0] x_in_hi_reg;
    logic signed [VW-1:0] y_lo_reg;
    logic signed [VW-1:0] y_hi_reg;
    logic signed [VW-1:0] y_in_lo_reg;
    logic signed [VW-1:0] y_in_hi_reg;
    logic [PW-1:0]        prod_reg;
    logic                 rd_in_reg;

    assign l_ext  = {{(VW-COORD_W){left_reg[COORD_W-1]}}, left_reg};
    assign t_ext  = {{(VW-COORD_W){top_reg[COORD_W-1]}}, top_reg};
    assign sx_ext = {{(VW-COORD_W){spx_reg[COORD_W-1]}}, spx_reg};
    assign sy_ext = {{(VW-COORD_W){spy_reg[COORD_W-1]}}, spy_reg};

    always_ff @(posedge clk)
    begin
        if (cmd.setup)
        begin
            x_lo_reg    <= l_ext;
            x_hi_reg    <= l_ext + sx_ext;
            x_in_lo_reg <= l_ext + ONE_FX;
            x_in_hi_reg <= l_ext + sx_ext - ONE_FX;
            y_lo_reg    <= t_ext;
            y_hi_reg    <= t_ext + sy_ext;
            y_in_lo_reg <= t_ext + ONE_FX;
            y_in_hi_reg <= t_ext + sy_ext - ONE_FX;
            prod_reg    <= PW'(rrow_reg) * PW'(w_eff);
            rd_in_reg   <= (int'(rcol_reg) < int'(w_eff)) && (int'(rrow_reg) < int'(h_eff));
        end
    end

    // sweep counters
    logic [WW-1:0] col_reg;
    logic [HW-1:0] row_reg;
    logic [AW-1:0] addr_reg;
    logic          last_col;
    logic          last_row;

    assign last_col = (col_reg == w_eff - WW'(1));
    assign last_row = (row_reg == h_eff - HW'(1));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg  <= '0;
            row_reg  <= '0;
            addr_reg <= '0;
        end
        else if (cmd.setup)
        begin
            col_reg  <= '0;
            row_reg  <= '0;
            addr_reg <= '0;
        end
        else if (cmd.sweep)
        begin
            addr_reg <= addr_reg + AW'(1);
            if (last_col)
            begin
                col_reg <= '0;
                row_reg <= row_reg + HW'(1);
            end
            else
            begin
                col_reg <= col_reg + WW'(1);
            end
        end
    end

    // pixel classification
    logic signed [VW-1:0] px;
    logic signed [VW-1:0] py;
    logic                 in_rect;
    logic                 edge_band;
    logic                 paint;

    assign px = {{(VW-WW-FRAC_BITS){1'b0}}, col_reg, {FRAC_BITS{1'b0}}};
    assign py = {{(VW-HW-FRAC_BITS){1'b0}}, row_reg, {FRAC_BITS{1'b0}}};

    assign in_rect   = (px >= x_lo_reg) && (px <= x_hi_reg)
                    && (py >= y_lo_reg) && (py <= y_hi_reg);
    assign edge_band = (px < x_in_lo_reg) || (px > x_in_hi_reg)
                    || (py < y_in_lo_reg) || (py > y_in_hi_reg);
    assign paint     = (req_reg == REQ_CLEAR)
                    || (in_rect && (edge_band || (kind_reg == KIND_FILLED)));

    // canvas memory
    logic [BYTE_W-1:0] mem [DEPTH];
    logic [BYTE_W-1:0] rd_data_reg;
    logic [BYTE_W-1:0] wdata;
    logic [SW-1:0]     rd_sum;
    logic              mem_we;
    logic              mem_re;

    assign wdata  = (req_reg == REQ_CLEAR) ? bg_reg : color_reg;
    assign mem_we = cmd.sweep && paint;
    assign mem_re = cmd.rd_en && rd_in_reg;
    assign rd_sum = SW'(prod_reg) + SW'(rcol_reg);

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[addr_reg] <= wdata;
        end
        if (mem_re)
        begin
            rd_data_reg <= mem[rd_sum[AW-1:0]];
        end
    end

    // result register
    logic              out_valid_reg;
    logic [1:0]        status_reg;
    logic [BYTE_W-1:0] pix_reg;
    stat_code_t        status_next;
    logic [BYTE_W-1:0] pix_next;

    always_comb
    begin
        status_next = STAT_OK;
        pix_next    = '0;
        unique case (req_reg)
            REQ_DRAW:
            begin
                if (reject)
                begin
                    status_next = STAT_REJECT;
                end
            end
            REQ_READ:
            begin
                if (rd_in_reg)
                begin
                    pix_next = rd_data_reg;
                end
                else
                begin
                    status_next = STAT_OUTSIDE;
                end
            end
            REQ_CLEAR, REQ_NONE:
            begin
                status_next = STAT_OK;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.load_result)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_result)
        begin
            status_reg <= status_next;
            pix_reg    <= pix_next;
        end
    end

    assign rsp.valid       = out_valid_reg;
    assign rsp.status      = status_reg;
    assign rsp.pixel_value = pix_reg;

    always_comb
    begin
        stat            = '0;
        stat.req        = req_reg;
        stat.reject     = reject;
        stat.empty      = (w_eff == '0) || (h_eff == '0);
        stat.last_pixel = last_col && last_row;
        stat.slot_free  = !out_valid_reg || rsp.ready;
    end

endmodule

`default_nettype wire

// ===== hdl/rectangle_outline_fill_raster.sv =====
// Top level of the rectangle rasterizer: sequencer plus datapath.
// Uses rofr_pkg, rofr_req_if, rofr_rsp_if, rofr_ctrl and rofr_datapath.
//
// Usage:
//   req carries one request beat (clear, draw, read); rsp returns exactly one
//   result beat per request, in order. cfg_we/cfg_index/cfg_data write the
//   canvas width, height and background byte; write them only while idle.
//   One request is in flight at a time; req.ready is high only when idle.
//   Steps from accept to result valid, with W by H pixels in use:
//     clear or accepted draw: decode, then a sweep over all W by H pixels (one
//       canvas write port, one pixel per cycle in raster order), then finish
//     rejected draw, empty canvas, unused type: decode, then finish
//     read: decode (row*width multiply), a registered memory read, then finish
//   The next request can be accepted in the cycle after a result loads.
//   Reset clears the sequencer, the result valid flag and the registers to
//   256 x 256 with a space background; canvas contents are undefined until
//   cleared or drawn, and no clearing pass runs after reset.
//   A result that is not taken holds rsp; the next request may be accepted
//   meanwhile and completes up to its result, then waits for the slot.
`default_nettype none

module rectangle_outline_fill_raster
    import rofr_pkg::*;
#(
    parameter int MAX_COLS  = 256,
    parameter int MAX_ROWS  = 256,
    parameter int FRAC_BITS = 8
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              cfg_we,
    input  wire logic [CIDX_W-1:0] cfg_index,
    input  wire logic [CFG_W-1:0]  cfg_data,
    rofr_req_if.sink               req,
    rofr_rsp_if.source             rsp
);

    ctl_cmd_t cmd;
    dp_stat_t stat;

    rofr_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (req.valid),
        .stat     (stat),
        .cmd      (cmd)
    );

    rofr_datapath #(
        .MAX_COLS  (MAX_COLS),
        .MAX_ROWS  (MAX_ROWS),
        .FRAC_BITS (FRAC_BITS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .req       (req),
        .rsp       (rsp),
        .cmd       (cmd),
        .stat      (stat)
    );

endmodule

`default_nettype wire

// ===== hdl/rofr_checker.sv =====
// Port-level checks for the rectangle rasterizer, bound to the top level.
// Uses rofr_pkg for status codes.
`default_nettype none

module rofr_props
    import rofr_pkg::*;
(
    input wire logic              clk,
    input wire logic              rst_n,
    input wire logic              in_valid,
    input wire logic              in_ready,
    input wire logic              out_valid,
    input wire logic              out_ready,
    input wire logic [1:0]        status,
    input wire logic [BYTE_W-1:0] pixel_value
);

    // one request at a time
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("ready stayed high after a request beat");

    // no result can appear the cycle right after an accept
    a_no_instant_result: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !$rose(out_valid))
        else $error("result appeared one cycle after accept");

    a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> out_valid)
        else $error("result beat dropped while stalled");

    a_pixel_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (status != STAT_OK)) |-> (pixel_value == '0))
        else $error("nonzero pixel on a failed request");

endmodule

bind rectangle_outline_fill_raster rofr_props u_rofr_props (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (req.valid),
    .in_ready    (req.ready),
    .out_valid   (rsp.valid),
    .out_ready   (rsp.ready),
    .status      (rsp.status),
    .pixel_value (rsp.pixel_value)
);

`default_nettype wire

// ===== tb/rofr_checker.sv =====
`timescale 1ns / 1ps
// Scoreboard for rectangle_outline_fill_raster: watches the config port and both channels,
// keeps its own canvas and registers, predicts each result beat and compares it.
// Depends on rofr_pkg, rofr_req_if and rofr_rsp_if.
module rofr_checker
    import rofr_pkg::*;
#(
    parameter int MAX_COLS  = 256,
    parameter int MAX_ROWS  = 256,
    parameter int FRAC_BITS = 8
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              cfg_we,
    input  wire logic [CIDX_W-1:0] cfg_index,
    input  wire logic [CFG_W-1:0]  cfg_data,
    rofr_req_if                    req,
    rofr_rsp_if                    rsp,
    output int                     mismatches,
    output int                     pending
);
    typedef struct packed {
        logic [1:0]        status;
        logic [BYTE_W-1:0] pixel;
    } result_t;

    logic [BYTE_W-1:0] canvas_mem [MAX_COLS*MAX_ROWS];
    logic [CFG_W-1:0]  cols_reg;
    logic [CFG_W-1:0]  rows_reg;
    logic [BYTE_W-1:0] bg_reg;
    result_t           expected_q[$];
    result_t           want;
    int                fails = 0;

    function automatic result_t render(
        input logic [1:0]                rtype,
        input logic [BYTE_W-1:0]         kind,
        input logic signed [COORD_W-1:0] left,
        input logic signed [COORD_W-1:0] top,
        input logic signed [COORD_W-1:0] span_x,
        input logic signed [COORD_W-1:0] span_y,
        input logic [BYTE_W-1:0]         color,
        input logic [POS_W-1:0]          col,
        input logic [POS_W-1:0]          row
    );
        result_t     res;
        int unsigned w;
        int unsigned h;
        int unsigned c;
        int unsigned r;
        longint      l;
        longint      t;
        longint      rgt;
        longint      bot;
        longint      px;
        longint      py;
        longint      one;
        logic        hit;
        logic        rim;
        res.status = STAT_OK;
        res.pixel  = '0;
        w = (cols_reg > MAX_COLS) ? MAX_COLS : cols_reg;
        h = (rows_reg > MAX_ROWS) ? MAX_ROWS : rows_reg;
        one = longint'(1) << FRAC_BITS;
        case (rtype)
            REQ_CLEAR:
            begin
                for (c = 0; c < w * h; c++)
                    canvas_mem[c] = bg_reg;
            end
            REQ_DRAW:
            begin
                if (span_x <= 0 || span_y <= 0 ||
                    (kind != KIND_FILLED && kind != KIND_OUTLINE))
                    res.status = STAT_REJECT;
                else
                begin
                    l   = left;
                    t   = top;
                    rgt = l + span_x;
                    bot = t + span_y;
                    for (r = 0; r < h; r++)
                    begin
                        for (c = 0; c < w; c++)
                        begin
                            px  = longint'(c) << FRAC_BITS;
                            py  = longint'(r) << FRAC_BITS;
                            hit = px >= l && px <= rgt && py >= t && py <= bot;
                            rim = px - l < one || rgt - px < one ||
                                  py - t < one || bot - py < one;
                            if (hit && (rim || kind == KIND_FILLED))
                                canvas_mem[c + r * w] = color;
                        end
                    end
                end
            end
            REQ_READ:
            begin
                if (col < w && row < h)
                    res.pixel = canvas_mem[col + row * w];
                else
                    res.status = STAT_OUTSIDE;
            end
            default:
            begin
            end
        endcase
        return res;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cols_reg = WIDTH_RESET;
            rows_reg = HEIGHT_RESET;
            bg_reg   = BG_RESET;
            expected_q.delete();
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_CANVAS_WIDTH:  cols_reg = cfg_data;
                    REG_CANVAS_HEIGHT: rows_reg = cfg_data;
                    REG_BACKGROUND:    bg_reg   = cfg_data[BYTE_W-1:0];
                    default:
                    begin
                    end
                endcase
            end
            if (rsp.valid && rsp.ready)
            begin
                if (expected_q.size() == 0)
                begin
                    fails++;
                    $display("%0t: unexpected result beat: expected none, got status %0d pixel 0x%02h",
                             $time, rsp.status, rsp.pixel_value);
                end
                else
                begin
                    want = expected_q.pop_front();
                    if (rsp.status !== want.status)
                    begin
                        fails++;
                        $display("%0t: status mismatch: expected %0d, got %0d",
                                 $time, want.status, rsp.status);
                    end
                    if (rsp.pixel_value !== want.pixel)
                    begin
                        fails++;
                        $display("%0t: pixel_value mismatch: expected 0x%02h, got 0x%02h",
                                 $time, want.pixel, rsp.pixel_value);
                    end
                end
            end
            if (req.valid && req.ready)
                expected_q.push_back(render(req.req_type, req.rect_kind, req.rect_left,
                                            req.rect_top, req.rect_span_x, req.rect_span_y,
                                            req.rect_color, req.read_col, req.read_row));
        end
        mismatches <= fails;
        pending    <= expected_q.size();
    end
endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
// Testbench top for rectangle_outline_fill_raster: clock, reset, register setup, request
// stimulus and response back-pressure; rofr_checker does the predicting and comparing.
// Depends on rofr_pkg, rofr_req_if, rofr_rsp_if and rofr_checker.
module tb;
    import rofr_pkg::*;

    localparam int MAX_COLS       = 256;
    localparam int MAX_ROWS       = 256;
    localparam int FRAC_BITS      = 8;
    localparam int ONE            = 1 << FRAC_BITS;
    localparam int RANDOM_ITEMS   = 70;
    localparam int STALL_MAX      = 16;
    localparam int HOLD_CYCLES    = 2000;
    localparam int SETTLE_CYCLES  = 8;
    localparam int WATCHDOG_LIMIT = 280000;

    localparam logic [CIDX_W-1:0] REG_SPARE  = 2'd3;
    localparam logic [BYTE_W-1:0] KIND_BOGUS = 8'h78;  // 'x'

    typedef struct {
        logic [1:0]                rtype;
        logic [BYTE_W-1:0]         kind;
        logic signed [COORD_W-1:0] left;
        logic signed [COORD_W-1:0] top;
        logic signed [COORD_W-1:0] span_x;
        logic signed [COORD_W-1:0] span_y;
        logic [BYTE_W-1:0]         color;
        logic [POS_W-1:0]          col;
        logic [POS_W-1:0]          row;
    } raster_req_t;

    logic              clk = 1'b0;
    logic              rst_n;
    logic              cfg_we;
    logic [CIDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]  cfg_data;
    int                mismatches;
    int                pending;

    bit          steady;
    bit          hold_rsp;
    int          n_clear;
    int          n_draw;
    int          n_read;
    int          n_unused;
    int          n_settings;
    int          random_items;
    int          phase_no;
    int          cols;
    int          rows;
    int          stall;
    int          idle_run;
    raster_req_t beat;

    rofr_req_if req_ch ();
    rofr_rsp_if rsp_ch ();

    rectangle_outline_fill_raster #(
        .MAX_COLS  (MAX_COLS),
        .MAX_ROWS  (MAX_ROWS),
        .FRAC_BITS (FRAC_BITS)
    ) u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .req       (req_ch),
        .rsp       (rsp_ch)
    );

    rofr_checker #(
        .MAX_COLS  (MAX_COLS),
        .MAX_ROWS  (MAX_ROWS),
        .FRAC_BITS (FRAC_BITS)
    ) u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .req        (req_ch),
        .rsp        (rsp_ch),
        .mismatches (mismatches),
        .pending    (pending)
    );

    always #2 clk = ~clk;

    function automatic logic signed [COORD_W-1:0] coord(input int v);
        return COORD_W'(v);
    endfunction

    function automatic raster_req_t noise_req();
        raster_req_t b;
        b.rtype  = 2'($urandom_range(0, 3));
        b.kind   = BYTE_W'($urandom);
        b.left   = COORD_W'($urandom);
        b.top    = COORD_W'($urandom);
        b.span_x = COORD_W'($urandom);
        b.span_y = COORD_W'($urandom);
        b.color  = BYTE_W'($urandom);
        b.col    = POS_W'($urandom);
        b.row    = POS_W'($urandom);
        return b;
    endfunction

    function automatic raster_req_t simple_req(input req_t rtype);
        raster_req_t b;
        b = noise_req();
        b.rtype = rtype;
        return b;
    endfunction

    function automatic raster_req_t read_req(input int col, input int row);
        raster_req_t b;
        b = simple_req(REQ_READ);
        b.col = POS_W'(col);
        b.row = POS_W'(row);
        return b;
    endfunction

    function automatic raster_req_t draw_req(input logic [BYTE_W-1:0] kind, input int l,
                                             input int t, input int sx, input int sy,
                                             input logic [BYTE_W-1:0] color);
        raster_req_t b;
        b = simple_req(REQ_DRAW);
        b.kind   = kind;
        b.left   = coord(l);
        b.top    = coord(t);
        b.span_x = coord(sx);
        b.span_y = coord(sy);
        b.color  = color;
        return b;
    endfunction

    function automatic raster_req_t random_req(input int w, input int h);
        raster_req_t b;
        int          pick;
        int          l;
        int          t;
        b = noise_req();
        pick = $urandom_range(0, 99);
        if (pick < 8)
            b.rtype = REQ_CLEAR;
        else if (pick < 13)
            b.rtype = REQ_NONE;
        else if (pick < 58)
        begin
            b.rtype = REQ_DRAW;
            // most draws well formed, the rest keep the noise fields
            if ($urandom_range(0, 9) < 8)
            begin
                b.kind = $urandom_range(0, 1) ? KIND_FILLED : KIND_OUTLINE;
                l = int'($urandom_range(0, (w + 4) * ONE)) - 2 * ONE;
                t = int'($urandom_range(0, (h + 4) * ONE)) - 2 * ONE;
                if ($urandom_range(0, 3) == 0)
                begin
                    l = l & ~(ONE - 1);
                    t = t & ~(ONE - 1);
                end
                b.left   = coord(l);
                b.top    = coord(t);
                b.span_x = coord($urandom_range(1, (w + 2) * ONE));
                b.span_y = coord($urandom_range(1, (h + 2) * ONE));
            end
        end
        else
        begin
            b.rtype = REQ_READ;
            if ($urandom_range(0, 9) < 8)
            begin
                b.col = POS_W'($urandom_range(0, w - 1));
                b.row = POS_W'($urandom_range(0, h - 1));
            end
        end
        return b;
    endfunction

    task automatic send(input raster_req_t b);
        int gap;
        gap = steady ? 0 : $urandom_range(0, STALL_MAX);
        if (gap > 0)
        begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_ch.valid       <= 1'b1;
        req_ch.req_type    <= b.rtype;
        req_ch.rect_kind   <= b.kind;
        req_ch.rect_left   <= b.left;
        req_ch.rect_top    <= b.top;
        req_ch.rect_span_x <= b.span_x;
        req_ch.rect_span_y <= b.span_y;
        req_ch.rect_color  <= b.color;
        req_ch.read_col    <= b.col;
        req_ch.read_row    <= b.row;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
        case (b.rtype)
            REQ_CLEAR: n_clear++;
            REQ_DRAW:  n_draw++;
            REQ_READ:  n_read++;
            default:   n_unused++;
        endcase
    endtask

    // leaves valid low, waits for every result, then lets the block settle
    task automatic drain();
        req_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic program_regs(input logic [CFG_W-1:0] w, input logic [CFG_W-1:0] h,
                                input logic [CFG_W-1:0] bg, input bit poke_spare);
        cfg_we    <= 1'b1;
        cfg_index <= REG_CANVAS_WIDTH;
        cfg_data  <= w;
        @(posedge clk);
        cfg_index <= REG_CANVAS_HEIGHT;
        cfg_data  <= h;
        @(posedge clk);
        cfg_index <= REG_BACKGROUND;
        cfg_data  <= bg;
        @(posedge clk);
        if (poke_spare)
        begin
            cfg_index <= REG_SPARE;
            cfg_data  <= '1;
            @(posedge clk);
        end
        cfg_we <= 1'b0;
        n_settings++;
    endtask

    // response side: random stalls per beat, one long hold-off on request
    initial
    begin
        rsp_ch.ready <= 1'b0;
        @(posedge clk);
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            if (hold_rsp)
            begin
                rsp_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_rsp = 1'b0;
            end
            else
            begin
                stall = steady ? 0 : $urandom_range(0, STALL_MAX);
                if (stall > 0)
                begin
                    rsp_ch.ready <= 1'b0;
                    repeat (stall) @(posedge clk);
                end
            end
            rsp_ch.ready <= 1'b1;
            @(posedge clk);
            while (!rsp_ch.valid)
                @(posedge clk);
        end
    end

    initial
    begin
        idle_run = 0;
        while (idle_run < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
                idle_run = 0;
            else
                idle_run++;
        end
        $display("%0t: timeout, no beat for %0d cycles", $time, WATCHDOG_LIMIT);
        $display("rectangle_outline_fill_raster test failed");
        $finish;
    end

    initial
    begin
        steady   = 1'b0;
        hold_rsp = 1'b0;
        rst_n              <= 1'b0;
        cfg_we             <= 1'b0;
        cfg_index          <= REG_CANVAS_WIDTH;
        cfg_data           <= '0;
        req_ch.valid       <= 1'b0;
        req_ch.req_type    <= REQ_NONE;
        req_ch.rect_kind   <= '0;
        req_ch.rect_left   <= '0;
        req_ch.rect_top    <= '0;
        req_ch.rect_span_x <= '0;
        req_ch.rect_span_y <= '0;
        req_ch.rect_color  <= '0;
        req_ch.read_col    <= '0;
        req_ch.read_row    <= '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset geometry; the full clear writes every canvas entry
        send(simple_req(REQ_CLEAR));
        send(read_req(0, 0));
        send(read_req(255, 255));
        drain();

        program_regs(9'd8, 9'd6, 9'h02E, 1'b0);
        send(simple_req(REQ_CLEAR));
        send(draw_req(KIND_OUTLINE, ONE, ONE, 4 * ONE + ONE / 2, 3 * ONE, 8'h41));
        send(draw_req(KIND_FILLED, -ONE / 2, 3 * ONE + ONE / 2, 5 * ONE / 2, 2 * ONE, 8'h42));
        send(draw_req(KIND_FILLED, -524288, -524288, 524287, 524287, 8'h00));
        send(draw_req(KIND_OUTLINE, 0, 0, 524287, 524287, 8'hFF));
        send(draw_req(KIND_FILLED, 2 * ONE, 2 * ONE, 1, 1, 8'h43));
        send(draw_req(KIND_BOGUS, 0, 0, 2 * ONE, 2 * ONE, 8'h44));
        send(draw_req(KIND_FILLED, 0, 0, 0, 2 * ONE, 8'h44));
        send(draw_req(KIND_OUTLINE, 0, 0, 2 * ONE, -ONE, 8'h44));
        send(draw_req('1, 524287, 0, -524288, ONE, 8'h44));
        send(read_req(2, 2));
        send(read_req(7, 5));
        send(read_req(0, 3));
        send(read_req(8, 0));
        send(read_req(0, 6));
        send(simple_req(REQ_NONE));
        drain();

        // empty canvas
        program_regs(9'd0, 9'd0, 9'h023, 1'b0);
        send(simple_req(REQ_CLEAR));
        send(draw_req(KIND_FILLED, 0, 0, 4 * ONE, 4 * ONE, 8'h45));
        send(read_req(0, 0));
        drain();

        // oversized dimensions saturate
        program_regs(9'h1FF, 9'd1, 9'h1FF, 1'b1);
        send(simple_req(REQ_CLEAR));
        send(draw_req(KIND_OUTLINE, 10 * ONE + ONE / 2, -ONE / 2, 100 * ONE, ONE, 8'h44));
        send(read_req(255, 0));
        send(read_req(50, 0));
        drain();

        program_regs(9'd1, 9'h1FF, 9'h000, 1'b0);
        send(simple_req(REQ_CLEAR));
        send(draw_req(KIND_FILLED, 0, 10 * ONE, ONE, 100 * ONE, 8'h45));
        send(read_req(0, 255));
        send(read_req(0, 50));
        drain();

        random_items = 0;
        phase_no = 0;
        while (random_items < RANDOM_ITEMS)
        begin
            // the hold-off phase keeps a small canvas so the block backs up
            if (($urandom_range(0, 5) == 0) && (phase_no != 2))
            begin
                cols = $urandom_range(1, MAX_COLS);
                rows = $urandom_range(1, 4096 / cols);
            end
            else
            begin
                cols = $urandom_range(1, 20);
                rows = $urandom_range(1, 20);
            end
            program_regs(CFG_W'(cols), CFG_W'(rows), CFG_W'($urandom_range(0, 511)), 1'b0);
            steady = ($urandom_range(0, 3) == 0);
            if (phase_no == 2)
                hold_rsp = 1'b1;
            repeat ($urandom_range(8, 16))
            begin
                beat = random_req(cols, (rows > MAX_ROWS) ? MAX_ROWS : rows);
                send(beat);
                if (beat.rtype != REQ_NONE)
                    random_items++;
            end
            drain();
            phase_no++;
        end

        $display("Covered %0d clears, %0d draws, %0d reads and %0d unused-type requests",
                 n_clear, n_draw, n_read, n_unused);
        $display("over %0d canvas settings, including empty and saturated geometries",
                 n_settings);
        if (mismatches == 0 && pending == 0)
            $display("rectangle_outline_fill_raster test passed");
        else
            $display("rectangle_outline_fill_raster test failed");
        $finish;
    end
endmodule
